// File: hdl/bwst_pkg.sv
`timescale 1ns / 1ps

package bwst_pkg;

  localparam int unsigned ADDR_W   = 32;
  localparam int unsigned SIZE_W   = 3;
  localparam int unsigned CYCLES_W = 5;
  localparam int unsigned PAGE_W   = 4;
  localparam int unsigned IDX_W    = 3;
  localparam int unsigned WAIT_W   = 2;

  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 8;

  typedef logic [CYCLES_W-1:0] cycles_t;
  typedef logic [PAGE_W-1:0]   page_t;
  typedef logic [IDX_W-1:0]    reg_idx_t;
  typedef logic [WAIT_W-1:0]   wait_sel_t;

  // Register indexes on the configuration port.
  localparam reg_idx_t REG_ROM0_FIRST = 3'd0;
  localparam reg_idx_t REG_ROM0_NEXT  = 3'd1;
  localparam reg_idx_t REG_ROM1_FIRST = 3'd2;
  localparam reg_idx_t REG_ROM1_NEXT  = 3'd3;
  localparam reg_idx_t REG_ROM2_FIRST = 3'd4;
  localparam reg_idx_t REG_ROM2_NEXT  = 3'd5;
  localparam reg_idx_t REG_BACKUP_RAM = 3'd6;

  // Transfer size codes.
  localparam logic [SIZE_W-1:0] SIZE_HALF = 3'd2;
  localparam logic [SIZE_W-1:0] SIZE_WORD = 3'd3;

  // Pages with a special meaning.
  localparam page_t PAGE_ROM_FIRST = 4'd8;
  localparam page_t PAGE_ROM0_LAST = 4'd9;
  localparam page_t PAGE_ROM1_LAST = 4'd11;
  localparam page_t PAGE_ROM2_LAST = 4'd13;
  localparam page_t PAGE_BACKUP    = 4'd14;
  localparam page_t PAGE_UNUSED    = 4'd15;

  localparam cycles_t FIXED_COST16 [8] = '{5'd1, 5'd1, 5'd3, 5'd1, 5'd1, 5'd1, 5'd1, 5'd1};
  localparam cycles_t FIXED_COST32 [8] = '{5'd1, 5'd1, 5'd6, 5'd1, 5'd1, 5'd2, 5'd2, 5'd1};
  localparam cycles_t FIRST_WAITS  [4] = '{5'd4, 5'd3, 5'd2, 5'd8};

endpackage

// File: hdl/bus_wait_state_timing.sv
`timescale 1ns / 1ps

// Channel  Direction  Ports                                Payload
// in       slave      in_tvalid in_tready in_tdata         address, size, sequential flag
// out      master     out_tvalid out_tready out_tdata      cycles, effective sequential flag
// cfg      slave      cfg_valid cfg_ready cfg_index cfg_data  wait-state register write
//
// Each transaction passes an input register and then a result register
// before its result is presented; one transaction can enter every cycle
// while out_tready holds no stall. The cost decode is a page compare and
// small table lookups. A stall on out_tready backs up through the input
// register; in_tready drops only when both stages hold data. rst_n clears
// the stage valids and the wait-state registers; cfg_ready is always high.

module bus_wait_state_timing (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [31:0] bus_address, [34:32] size_bytes, [35] is_sequential, [39:36] zero
  input  logic [bwst_pkg::IN_TDATA_W-1:0]    in_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [4:0] access_cycles, [5] used_sequential, [7:6] zero
  output logic [bwst_pkg::OUT_TDATA_W-1:0]   out_tdata,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [bwst_pkg::IDX_W-1:0]         cfg_index,
  input  logic [bwst_pkg::WAIT_W-1:0]        cfg_data
);

  import bwst_pkg::*;

  wait_sel_t rom0_first_r, rom1_first_r, rom2_first_r, backup_r;
  logic      rom0_next_r, rom1_next_r, rom2_next_r;

  logic                in_valid_r;
  logic [ADDR_W-1:0]   addr_r;
  logic [SIZE_W-1:0]   size_r;
  logic                seq_r;

  logic                out_valid_r;
  cycles_t             cycles_r;
  logic                used_seq_r;

  logic                out_load;
  logic                in_load;

  logic [ADDR_W-1:0]   addr_al;
  logic                wide;
  page_t               page;
  logic                seq_eff;
  cycles_t             first, next, n16, s16;
  cycles_t             cycles_nxt;

  assign cfg_ready  = 1'b1;
  assign out_load   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready  = !in_valid_r || out_load;
  assign in_load    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, used_seq_r, cycles_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rom0_first_r <= '0;
      rom0_next_r  <= 1'b0;
      rom1_first_r <= '0;
      rom1_next_r  <= 1'b0;
      rom2_first_r <= '0;
      rom2_next_r  <= 1'b0;
      backup_r     <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ROM0_FIRST: rom0_first_r <= cfg_data;
        REG_ROM0_NEXT:  rom0_next_r  <= cfg_data[0];
        REG_ROM1_FIRST: rom1_first_r <= cfg_data;
        REG_ROM1_NEXT:  rom1_next_r  <= cfg_data[0];
        REG_ROM2_FIRST: rom2_first_r <= cfg_data;
        REG_ROM2_NEXT:  rom2_next_r  <= cfg_data[0];
        REG_BACKUP_RAM: backup_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      if (!out_valid_r || out_tready) begin
        out_valid_r <= in_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_load) begin
      addr_r <= in_tdata[31:0];
      size_r <= in_tdata[34:32];
      seq_r  <= in_tdata[35];
    end
    if (out_load) begin
      cycles_r   <= cycles_nxt;
      used_seq_r <= seq_eff;
    end
  end

  always_comb begin
    addr_al = addr_r;
    if (size_r == SIZE_HALF) begin
      addr_al[0] = 1'b0;
    end else if (size_r >= SIZE_WORD) begin
      addr_al[1:0] = 2'b00;
    end
    wide = (size_r >= SIZE_WORD);
    page = addr_al[27:24];

    // Cartridge ROM restarts the burst on every 128 KiB boundary.
    seq_eff = seq_r;
    if (page >= PAGE_ROM_FIRST && page <= PAGE_ROM2_LAST && addr_al[16:0] == 17'd0) begin
      seq_eff = 1'b0;
    end

    case (page) inside
      [PAGE_ROM_FIRST:PAGE_ROM0_LAST]: begin
        first = FIRST_WAITS[rom0_first_r];
        next  = rom0_next_r ? 5'd1 : 5'd2;
      end
      [4'd10:PAGE_ROM1_LAST]: begin
        first = FIRST_WAITS[rom1_first_r];
        next  = rom1_next_r ? 5'd1 : 5'd4;
      end
      [4'd12:PAGE_ROM2_LAST]: begin
        first = FIRST_WAITS[rom2_first_r];
        next  = rom2_next_r ? 5'd1 : 5'd8;
      end
      default: begin
        first = FIRST_WAITS[backup_r];
        next  = first;
      end
    endcase
    n16 = 5'(first + 5'd1);
    s16 = 5'(next + 5'd1);

    if (!page[3]) begin
      cycles_nxt = wide ? FIXED_COST32[page[2:0]] : FIXED_COST16[page[2:0]];
    end else if (page == PAGE_UNUSED) begin
      cycles_nxt = 5'd1;
    end else if (wide) begin
      cycles_nxt = seq_eff ? 5'(s16 + s16) : 5'(n16 + s16);
    end else begin
      cycles_nxt = seq_eff ? s16 : n16;
    end
  end

endmodule

// File: bench/tb_bus_wait_state_timing.sv
`timescale 1ns / 1ps

module tb_bus_wait_state_timing;
  import bwst_pkg::*;

  localparam int IDLE_LIMIT = 2000;

  // Transfer sizes in bytes as they travel on the input channel.
  localparam logic [SIZE_W-1:0] SZ_BYTE = 3'd1;
  localparam logic [SIZE_W-1:0] SZ_HALF = 3'd2;
  localparam logic [SIZE_W-1:0] SZ_WORD = 3'd4;

  // Index past the last register; a write there must change nothing.
  localparam reg_idx_t REG_NONE = 3'd7;

  typedef struct packed {
    cycles_t cycles;
    logic    seq;
  } access_cost_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_valid;
  logic                   cfg_ready;
  reg_idx_t               cfg_index;
  wait_sel_t              cfg_data;

  // Copy of the wait-state registers as the block should hold them.
  wait_sel_t    wait_sel [0:6];
  access_cost_t pending_costs [$];
  access_cost_t expected_cost;
  int           send_idle_pct;
  int           recv_idle_pct;
  int           mismatches;
  int           quiet_cycles;

  bus_wait_state_timing uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int first_waits(wait_sel_t sel);
    case (sel)
      2'd0:    return 4;
      2'd1:    return 3;
      2'd2:    return 2;
      default: return 8;
    endcase
  endfunction

  function automatic access_cost_t access_cost(logic [31:0] addr, logic [SIZE_W-1:0] size,
                                               logic seq);
    access_cost_t cost;
    logic [31:0]  a;
    page_t        pg;
    logic         wide;
    int           first;
    int           next;
    int           n16;
    int           s16;
    int           cyc;
    int           fixed16 [8];
    int           fixed32 [8];
    fixed16 = '{1, 1, 3, 1, 1, 1, 1, 1};
    fixed32 = '{1, 1, 6, 1, 1, 2, 2, 1};
    a = addr;
    if (size == SZ_HALF) begin
      a[0] = 1'b0;
    end else if (size > SZ_HALF) begin
      a[1:0] = 2'b00;
    end
    wide = (size > SZ_HALF);
    pg = a[27:24];
    // A ROM access on a 128 KiB boundary is always charged as non-sequential.
    if (pg >= PAGE_ROM_FIRST && pg <= PAGE_ROM2_LAST && a[16:0] == 17'd0) begin
      seq = 1'b0;
    end
    if (pg < PAGE_ROM_FIRST) begin
      cyc = wide ? fixed32[pg] : fixed16[pg];
    end else if (pg == PAGE_UNUSED) begin
      cyc = 1;
    end else begin
      if (pg <= PAGE_ROM0_LAST) begin
        first = first_waits(wait_sel[REG_ROM0_FIRST]);
        next  = wait_sel[REG_ROM0_NEXT][0] ? 1 : 2;
      end else if (pg <= PAGE_ROM1_LAST) begin
        first = first_waits(wait_sel[REG_ROM1_FIRST]);
        next  = wait_sel[REG_ROM1_NEXT][0] ? 1 : 4;
      end else if (pg <= PAGE_ROM2_LAST) begin
        first = first_waits(wait_sel[REG_ROM2_FIRST]);
        next  = wait_sel[REG_ROM2_NEXT][0] ? 1 : 8;
      end else begin
        first = first_waits(wait_sel[REG_BACKUP_RAM]);
        next  = first;
      end
      n16 = 1 + first;
      s16 = 1 + next;
      if (wide) begin
        cyc = seq ? 2 * s16 : n16 + s16;
      end else begin
        cyc = seq ? s16 : n16;
      end
    end
    cost.cycles = cycles_t'(cyc);
    cost.seq    = seq;
    return cost;
  endfunction

  task automatic send_access(logic [31:0] addr, logic [SIZE_W-1:0] size, logic seq);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = {4'b0000, seq, size, addr};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_costs.push_back(access_cost(addr, size, seq));
  endtask

  // Holds the sender off until every outstanding transaction has come back.
  task automatic wait_drained;
    @(negedge clk);
    in_tvalid = 1'b0;
    while (pending_costs.size() != 0) @(posedge clk);
  endtask

  task automatic write_wait_reg(reg_idx_t idx, wait_sel_t val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx <= REG_BACKUP_RAM) begin
      if (idx == REG_ROM0_NEXT || idx == REG_ROM1_NEXT || idx == REG_ROM2_NEXT) begin
        wait_sel[idx] = {1'b0, val[0]};
      end else begin
        wait_sel[idx] = val;
      end
    end
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic randomize_waits;
    for (int i = 0; i <= REG_BACKUP_RAM; i++) begin
      write_wait_reg(reg_idx_t'(i), wait_sel_t'($urandom_range(3)));
    end
    if ($urandom_range(3) == 0) begin
      write_wait_reg(REG_NONE, wait_sel_t'($urandom_range(3)));
    end
  endtask

  task automatic send_random_access;
    logic [31:0]       addr;
    logic [SIZE_W-1:0] size;
    addr = $urandom;
    // Most traffic goes to the pages whose cost depends on the registers.
    if ($urandom_range(9) < 6) begin
      addr[27:24] = page_t'($urandom_range(14, 8));
    end
    if ($urandom_range(9) < 2) begin
      addr[16:0] = {15'd0, 2'($urandom_range(3))};
    end
    if ($urandom_range(9) < 8) begin
      case ($urandom_range(2))
        0:       size = SZ_BYTE;
        1:       size = SZ_HALF;
        default: size = SZ_WORD;
      endcase
    end else begin
      size = SIZE_W'($urandom_range(7));
    end
    send_access(addr, size, 1'($urandom_range(1)));
  endtask

  // Reset settings: every page once, both sizes, both access types.
  task automatic test_page_map;
    for (int p = 0; p < 16; p++) begin
      send_access({4'($urandom), 4'(p), 24'($urandom)}, p[0] ? SZ_WORD : SZ_BYTE, p[1]);
    end
    wait_drained;
  endtask

  task automatic test_rom_boundary;
    send_access(32'h0800_0000, SZ_WORD, 1'b1);
    send_access(32'h09FE_0000, SZ_HALF, 1'b1);
    send_access(32'h0A00_0001, SZ_HALF, 1'b1);   // aligns onto the boundary
    send_access(32'h0D02_0003, SZ_WORD, 1'b1);   // aligns onto the boundary
    send_access(32'h0C00_0001, 3'd0, 1'b1);      // size code 0, handled like a byte access with no alignment
    send_access(32'h0801_FFFF, SZ_BYTE, 1'b1);
    send_access(32'h0E00_0000, SZ_WORD, 1'b1);   // backup RAM ignores the boundary
    send_access(32'hF800_0000, SZ_BYTE, 1'b1);
    send_access(32'hFFFF_FFFF, SZ_BYTE, 1'b1);
    send_access(32'h0000_0000, 3'd7, 1'b0);
    send_access(32'h0B00_0002, 3'd3, 1'b0);
    send_access(32'h0C00_0003, 3'd5, 1'b1);
    wait_drained;
  endtask

  task automatic test_wait_extremes;
    for (int i = 0; i <= REG_BACKUP_RAM; i++) begin
      write_wait_reg(reg_idx_t'(i), 2'd3);
    end
    send_access(32'h0800_0004, SZ_WORD, 1'b1);
    send_access(32'h0A12_3456, SZ_HALF, 1'b0);
    send_access(32'h0D00_0000, SZ_WORD, 1'b0);
    send_access(32'h0E00_0010, SZ_WORD, 1'b1);
    wait_drained;
    // The sequential wait registers keep only their low bit.
    write_wait_reg(REG_ROM0_NEXT, 2'd2);
    write_wait_reg(REG_ROM1_NEXT, 2'd2);
    write_wait_reg(REG_ROM2_NEXT, 2'd2);
    write_wait_reg(REG_NONE, 2'd1);
    send_access(32'h0900_0008, SZ_WORD, 1'b1);
    send_access(32'h0B00_0100, SZ_WORD, 1'b1);
    send_access(32'h0C00_0040, SZ_WORD, 1'b1);
    send_access(32'h0E00_0000, SZ_HALF, 1'b0);
    wait_drained;
  endtask

  task automatic test_random_traffic(int items, int send_pct, int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int chunk = 0; chunk < 3; chunk++) begin
      randomize_waits();
      for (int n = 0; n < items / 3; n++) begin
        send_random_access();
      end
      wait_drained;
    end
  endtask

  always @(negedge clk) begin
    out_tready = ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_costs.size() == 0) begin
        $display("%0t: unexpected transaction, cycles %0d sequential %0b", $time,
                 out_tdata[4:0], out_tdata[5]);
        mismatches++;
      end else begin
        expected_cost = pending_costs.pop_front();
        if (out_tdata[4:0] !== expected_cost.cycles) begin
          $display("%0t: access_cycles expected %0d actual %0d", $time,
                   expected_cost.cycles, out_tdata[4:0]);
          mismatches++;
        end
        if (out_tdata[5] !== expected_cost.seq) begin
          $display("%0t: used_sequential expected %0b actual %0b", $time,
                   expected_cost.seq, out_tdata[5]);
          mismatches++;
        end
      end
    end
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("bus_wait_state_timing regression: fail");
      $finish;
    end
  end

  initial begin
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    out_tready    = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    send_idle_pct = 16;
    recv_idle_pct = 59;
    mismatches    = 0;
    quiet_cycles  = 0;
    for (int i = 0; i <= REG_BACKUP_RAM; i++) begin
      wait_sel[i] = '0;
    end
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_page_map();
    test_rom_boundary();
    test_wait_extremes();
    test_random_traffic(270, 16, 59);
    test_random_traffic(270, 59, 16);
    test_random_traffic(264, 0, 0);

    wait_drained;
    repeat (8) @(posedge clk);
    if (mismatches == 0 && pending_costs.size() == 0) begin
      $display("bus_wait_state_timing regression: pass");
    end else begin
      $display("bus_wait_state_timing regression: fail");
    end
    $finish;
  end

endmodule

// File: bus_wait_state_timing.f
hdl/bwst_pkg.sv
hdl/bus_wait_state_timing.sv
bench/tb_bus_wait_state_timing.sv
